@@ design/phe_pkg.sv @@
package phe_pkg;

   // request kinds
   localparam logic [1:0] KIND_COUNT      = 2'd0;
   localparam logic [1:0] KIND_READ       = 2'd1;
   localparam logic [1:0] KIND_READ_CLEAR = 2'd2;

   localparam int PIXEL_BITS  = 16;
   localparam int INDEX_BITS  = 12;
   localparam int RESULT_BITS = 32;

   // what the update stage does with one request
   typedef struct packed {
      logic valid;
      logic count;   // saturating increment, return new value
      logic read;    // return stored value
      logic clear;   // zero the bin after reading
      logic flag;    // bin does not exist
   } phe_op_type;

   typedef struct packed {
      logic [RESULT_BITS-1:0] bin_count;
      logic                   out_of_range;
   } phe_result_type;

endpackage

@@ design/phe_channels.sv @@
interface phe_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           kind;
   logic signed [phe_pkg::PIXEL_BITS-1:0] pixel_value;
   logic [phe_pkg::INDEX_BITS-1:0]       bin_index;

   modport source (output valid, kind, pixel_value, bin_index, input ready);
   modport sink   (input valid, kind, pixel_value, bin_index, output ready);
endinterface

interface phe_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [phe_pkg::RESULT_BITS-1:0]  bin_count;
   logic                             out_of_range;

   modport source (output valid, bin_count, out_of_range, input ready);
   modport sink   (input valid, bin_count, out_of_range, output ready);
endinterface

interface phe_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [phe_pkg::PIXEL_BITS-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ design/phe_ram.sv @@
module phe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/phe_update.sv @@
module phe_update #(
   parameter int ADDR_BITS  = 12,
   parameter int COUNT_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  phe_pkg::phe_op_type    op,
   input  logic [ADDR_BITS-1:0]   addr,
   input  logic [COUNT_BITS-1:0]  rd_data,
   output logic                   wr_en,
   output logic [ADDR_BITS-1:0]   wr_addr,
   output logic [COUNT_BITS-1:0]  wr_data,
   output phe_pkg::phe_result_type result
);

   // last write, for a read issued in the same cycle as that write
   logic                  fwd_valid_ff, fwd_valid_in;
   logic [ADDR_BITS-1:0]  fwd_addr_ff;
   logic [COUNT_BITS-1:0] fwd_data_ff;

   logic [COUNT_BITS-1:0] cur;
   logic [COUNT_BITS-1:0] incr;
   logic [COUNT_BITS-1:0] ret;
   logic [COUNT_BITS+phe_pkg::RESULT_BITS-1:0] ret_ext;

   always_comb begin
      cur  = (fwd_valid_ff && fwd_addr_ff == addr) ? fwd_data_ff : rd_data;
      incr = (&cur) ? cur : cur + COUNT_BITS'(1);

      wr_en   = op.valid && (op.count || op.clear);
      wr_addr = addr;
      wr_data = op.count ? incr : '0;

      ret = '0;
      if (op.count) begin
         ret = incr;
      end else if (op.read) begin
         ret = cur;
      end
      ret_ext = {{phe_pkg::RESULT_BITS{1'b0}}, ret};

      result.bin_count    = ret_ext[phe_pkg::RESULT_BITS-1:0];
      result.out_of_range = op.flag;
      fwd_valid_in        = wr_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= fwd_valid_in;
      end
      fwd_addr_ff <= wr_addr;
      fwd_data_ff <= wr_data;
   end

endmodule

@@ design/phe_out_fifo.sv @@
module phe_out_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  phe_pkg::phe_result_type push_data,
   input  logic                   pop,
   output logic                   not_empty,
   output phe_pkg::phe_result_type head,
   output logic [1:0]             occupancy
);

   phe_pkg::phe_result_type entry_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wptr_in  = push ? ~wptr_ff : wptr_ff;
      rptr_in  = pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         entry_ff[wptr_ff] <= push_data;
      end
   end

   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rptr_ff];
   assign occupancy = count_ff;

endmodule

@@ design/pixel_histogram_engine.sv @@
// channel   | dir | handshake   | payload
// ----------+-----+-------------+---------------------------------------------
// req_chan  | in  | valid/ready | kind, pixel_value, bin_index
// rsp_chan  | out | valid/ready | bin_count, out_of_range (one per request)
// csr_chan  | in  | valid/ready | data -> min_pixel_value (always ready)
//
// One request per clock when the response side keeps up; each request passes
// the bin RAM read, then the modify/write stage, before the output buffer.
// Back-to-back hits on one bin are served from the last-write bypass.
// After reset a sweep zeroes the bin RAM, with req ready low.
// A stalled response side fills the 2-entry output buffer, then drops ready.
module pixel_histogram_engine #(
   parameter int NUM_BINS   = 4096,
   parameter int COUNT_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   phe_req_if.sink   req_chan,
   phe_rsp_if.source rsp_chan,
   phe_csr_if.sink   csr_chan
);

   localparam int ADDR_BITS = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int WIDE_BITS = 18;   // holds any pixel offset and NUM_BINS

   // configuration
   logic signed [phe_pkg::PIXEL_BITS-1:0] min_pixel_ff;

   // clearing sweep
   logic                 clr_busy_ff, clr_busy_in;
   logic [ADDR_BITS-1:0] clr_addr_ff, clr_addr_in;

   // decode stage
   logic                        accept;
   phe_pkg::phe_op_type         dec_op;
   logic [ADDR_BITS-1:0]        dec_addr;
   logic signed [WIDE_BITS-1:0] offset;
   logic [WIDE_BITS-1:0]        index_wide;
   logic                        offset_ok;
   logic                        index_ok;

   // update stage
   phe_pkg::phe_op_type  s1_op_ff, s1_op_in;
   logic [ADDR_BITS-1:0] s1_addr_ff;

   // RAM ports
   logic                  upd_wr_en;
   logic [ADDR_BITS-1:0]  upd_wr_addr;
   logic [COUNT_BITS-1:0] upd_wr_data;
   logic                  ram_wr_en;
   logic [ADDR_BITS-1:0]  ram_wr_addr;
   logic [COUNT_BITS-1:0] ram_wr_data;
   logic [COUNT_BITS-1:0] ram_rd_data;

   // output buffer
   phe_pkg::phe_result_type upd_result;
   phe_pkg::phe_result_type fifo_head;
   logic                    fifo_not_empty;
   logic [1:0]              fifo_occ;
   logic                    pop;
   logic [2:0]              load_after;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_pixel_ff <= '0;
      end else if (csr_chan.valid) begin
         min_pixel_ff <= csr_chan.data;
      end
   end

   // sweep writes zero into every bin, one per cycle
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         if (clr_addr_ff == ADDR_BITS'(NUM_BINS - 1)) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + ADDR_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // space check: whatever sits in the buffer or the update stage after this
   // cycle, plus a new request, must fit the two buffer entries
   assign pop        = fifo_not_empty && rsp_chan.ready;
   assign load_after = 3'(fifo_occ) + 3'(s1_op_ff.valid) - 3'(pop);
   assign req_chan.ready = !clr_busy_ff && (load_after <= 3'd1);
   assign accept     = req_chan.valid && req_chan.ready;

   // decode: bin address and range check
   always_comb begin
      offset     = WIDE_BITS'(req_chan.pixel_value) - WIDE_BITS'(min_pixel_ff);
      index_wide = WIDE_BITS'(req_chan.bin_index);
      offset_ok  = !offset[WIDE_BITS-1] && (offset < WIDE_BITS'(NUM_BINS));
      index_ok   = index_wide < WIDE_BITS'(NUM_BINS);

      dec_op       = '0;
      dec_op.valid = accept;
      dec_addr     = index_wide[ADDR_BITS-1:0];
      unique case (req_chan.kind)
         phe_pkg::KIND_COUNT: begin
            dec_addr     = offset[ADDR_BITS-1:0];
            dec_op.count = offset_ok;
            dec_op.flag  = !offset_ok;
         end
         phe_pkg::KIND_READ: begin
            dec_op.read = index_ok;
            dec_op.flag = !index_ok;
         end
         phe_pkg::KIND_READ_CLEAR: begin
            dec_op.read  = index_ok;
            dec_op.clear = index_ok;
            dec_op.flag  = !index_ok;
         end
         default: begin
            // unused kind: zero result, no change
         end
      endcase
      s1_op_in = dec_op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_op_ff <= '0;
      end else begin
         s1_op_ff <= s1_op_in;
      end
      s1_addr_ff <= dec_addr;
   end

   // sweep owns the write port until it finishes
   always_comb begin
      if (clr_busy_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = upd_wr_en;
         ram_wr_addr = upd_wr_addr;
         ram_wr_data = upd_wr_data;
      end
   end

   phe_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (NUM_BINS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (dec_addr),
      .rd_data (ram_rd_data)
   );

   phe_update #(
      .ADDR_BITS  (ADDR_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_update (
      .clock   (clock),
      .reset   (reset),
      .op      (s1_op_ff),
      .addr    (s1_addr_ff),
      .rd_data (ram_rd_data),
      .wr_en   (upd_wr_en),
      .wr_addr (upd_wr_addr),
      .wr_data (upd_wr_data),
      .result  (upd_result)
   );

   phe_out_fifo u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_op_ff.valid),
      .push_data (upd_result),
      .pop       (pop),
      .not_empty (fifo_not_empty),
      .head      (fifo_head),
      .occupancy (fifo_occ)
   );

   assign rsp_chan.valid        = fifo_not_empty;
   assign rsp_chan.bin_count    = fifo_head.bin_count;
   assign rsp_chan.out_of_range = fifo_head.out_of_range;

endmodule

@@ test/tb_pixel_histogram_engine.sv @@
module tb_pixel_histogram_engine;
   timeunit 1ns;
   timeprecision 1ps;

   // block configuration, as built by default
   localparam int NUM_BINS   = 4096;
   localparam int COUNT_BITS = 32;

   localparam int PIXEL_BITS  = phe_pkg::PIXEL_BITS;
   localparam int INDEX_BITS  = phe_pkg::INDEX_BITS;
   localparam int RESULT_BITS = phe_pkg::RESULT_BITS;

   // kind code the block leaves alone
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam int RSP_LATENCY     = 8;        // pipeline plus output buffer, with margin
   localparam int LONG_HOLD       = 300;      // response side hold-off, in cycles
   localparam int ITEMS_PER_PHASE = 200;
   localparam int PHASES          = 6;
   localparam int CYCLE_LIMIT     = 1_000_000;

   typedef struct packed {
      logic [1:0]                   kind;
      logic signed [PIXEL_BITS-1:0] pixel_value;
      logic [INDEX_BITS-1:0]        bin_index;
   } histo_req_type;

   // one line of the directed table; result only counts when known is set
   typedef struct packed {
      histo_req_type           req;
      logic                    known;
      phe_pkg::phe_result_type result;
   } directed_row_type;

   logic clock;
   logic reset;

   phe_req_if req_chan ();
   phe_rsp_if rsp_chan ();
   phe_csr_if csr_chan ();

   pixel_histogram_engine #(
      .NUM_BINS   (NUM_BINS),
      .COUNT_BITS (COUNT_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // own copy of the histogram and of the minimum pixel register
   logic [COUNT_BITS-1:0]        bin_tally [NUM_BINS];
   logic signed [PIXEL_BITS-1:0] floor_value;

   // results still owed by the block, oldest first
   phe_pkg::phe_result_type pending_results [$];

   int  mismatches = 0;
   int  cycle_count = 0;
   bit  tx_steady;
   bit  hold_off_request;

   // Directed requests, minimum pixel value at its reset value of zero.
   // Rows with known set carry a result that is plain at a glance; the rest
   // go through the histogram predictor.
   directed_row_type directed_rows [24] = '{
      // fresh store reads back zero, both ends
      '{'{phe_pkg::KIND_READ,       16'sd0,    12'd0},    1'b1, '{32'd0, 1'b0}},
      '{'{phe_pkg::KIND_READ,       16'sh7fff, 12'hfff},  1'b1, '{32'd0, 1'b0}},
      '{'{phe_pkg::KIND_READ_CLEAR, -16'sd1,   12'd17},   1'b1, '{32'd0, 1'b0}},
      // back-to-back hits on bin 0 exercise the write bypass
      '{'{phe_pkg::KIND_COUNT,      16'sd0,    12'hfff},  1'b1, '{32'd1, 1'b0}},
      '{'{phe_pkg::KIND_COUNT,      16'sd0,    12'd0},    1'b1, '{32'd2, 1'b0}},
      '{'{phe_pkg::KIND_COUNT,      16'sd0,    12'hfff},  1'b1, '{32'd3, 1'b0}},
      '{'{phe_pkg::KIND_COUNT,      16'sd4095, 12'd0},    1'b1, '{32'd1, 1'b0}},
      // pixels falling outside the bins: dropped and flagged
      '{'{phe_pkg::KIND_COUNT,      16'sd4096, 12'd0},    1'b1, '{32'd0, 1'b1}},
      '{'{phe_pkg::KIND_COUNT,      -16'sd1,   12'hfff},  1'b1, '{32'd0, 1'b1}},
      '{'{phe_pkg::KIND_COUNT,      16'sh8000, 12'd0},    1'b1, '{32'd0, 1'b1}},
      '{'{phe_pkg::KIND_COUNT,      16'sh7fff, 12'hfff},  1'b1, '{32'd0, 1'b1}},
      // unused kind touches nothing
      '{'{KIND_UNUSED,              16'sd0,    12'd0},    1'b1, '{32'd0, 1'b0}},
      '{'{KIND_UNUSED,              -16'sd1,   12'hfff},  1'b1, '{32'd0, 1'b0}},
      // read, read-and-clear, then read of the cleared bin
      '{'{phe_pkg::KIND_READ,       16'sd0,    12'd0},    1'b1, '{32'd3, 1'b0}},
      '{'{phe_pkg::KIND_READ_CLEAR, 16'sd0,    12'd0},    1'b1, '{32'd3, 1'b0}},
      '{'{phe_pkg::KIND_READ,       16'sd0,    12'd0},    1'b1, '{32'd0, 1'b0}},
      '{'{phe_pkg::KIND_COUNT,      16'sd0,    12'd0},    1'b1, '{32'd1, 1'b0}},
      '{'{phe_pkg::KIND_READ_CLEAR, 16'sd0,    12'hfff},  1'b1, '{32'd1, 1'b0}},
      '{'{phe_pkg::KIND_COUNT,      16'sd4095, 12'd0},    1'b1, '{32'd1, 1'b0}},
      // count and read interleaved on one bin, left to the predictor
      '{'{phe_pkg::KIND_COUNT,      16'sd1234, 12'd0},    1'b0, '0},
      '{'{phe_pkg::KIND_READ,       16'sd0,    12'd1234}, 1'b0, '0},
      '{'{phe_pkg::KIND_COUNT,      16'sd1234, 12'd0},    1'b0, '0},
      '{'{phe_pkg::KIND_READ_CLEAR, 16'sd0,    12'd1234}, 1'b0, '0},
      '{'{phe_pkg::KIND_READ,       16'sd0,    12'd1234}, 1'b0, '0}
   };

   // Works out the result of one request and updates the local histogram.
   function automatic phe_pkg::phe_result_type histogram_update(histo_req_type r);
      int                      offset;
      phe_pkg::phe_result_type res;
      res = '0;
      case (r.kind)
         phe_pkg::KIND_COUNT: begin
            offset = $signed(r.pixel_value) - $signed(floor_value);
            if (offset < 0 || offset >= NUM_BINS) begin
               res.out_of_range = 1'b1;
            end else begin
               // saturate, never wrap
               if (bin_tally[offset] != '1)
                  bin_tally[offset] = bin_tally[offset] + 1'b1;
               res.bin_count = RESULT_BITS'(bin_tally[offset]);
            end
         end
         phe_pkg::KIND_READ, phe_pkg::KIND_READ_CLEAR: begin
            if (int'(r.bin_index) >= NUM_BINS) begin
               res.out_of_range = 1'b1;
            end else begin
               res.bin_count = RESULT_BITS'(bin_tally[r.bin_index]);
               if (r.kind == phe_pkg::KIND_READ_CLEAR)
                  bin_tally[r.bin_index] = '0;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // mostly back-to-back, sometimes a short gap, now and then a long gap
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         return 0;
      else if (roll < 95)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 40);
   endfunction

   // Random request, biased towards pixels that land in the bins and towards
   // a small window of hot bins so that counts build up and get read back.
   function automatic histo_req_type random_request(int hot_base);
      histo_req_type r;
      int            choice;
      int            offset;
      r.kind        = phe_pkg::KIND_COUNT;
      r.pixel_value = PIXEL_BITS'($urandom);
      r.bin_index   = INDEX_BITS'($urandom);
      choice        = $urandom_range(0, 99);
      offset        = 0;
      if (choice < 64) begin
         if (choice < 30)
            offset = hot_base + $urandom_range(0, 15);
         else if (choice < 50)
            offset = $urandom_range(0, NUM_BINS - 1);
         else if (choice < 58) begin
            case ($urandom_range(0, 3))
               0:       offset = -1;
               1:       offset = 0;
               2:       offset = NUM_BINS - 1;
               default: offset = NUM_BINS;
            endcase
         end
         // choice 58..63: pixel left as pure noise
         if (choice < 58)
            r.pixel_value = PIXEL_BITS'(int'(floor_value) + offset);
      end else if (choice < 97) begin
         r.kind = (choice < 82) ? phe_pkg::KIND_READ : phe_pkg::KIND_READ_CLEAR;
         if ($urandom_range(0, 3) != 0)
            r.bin_index = INDEX_BITS'(hot_base + $urandom_range(0, 15));
      end else begin
         r.kind = KIND_UNUSED;
      end
      return r;
   endfunction

   // Offer one request, wait for the handshake, then log what the block owes.
   task automatic issue_request(input histo_req_type r, input logic known,
                                input phe_pkg::phe_result_type typed_result);
      phe_pkg::phe_result_type predicted;
      req_chan.valid       <= 1'b1;
      req_chan.kind        <= r.kind;
      req_chan.pixel_value <= r.pixel_value;
      req_chan.bin_index   <= r.bin_index;
      do @(posedge clock); while (!req_chan.ready);
      predicted = histogram_update(r);
      pending_results.push_back(known ? typed_result : predicted);
   endtask

   // valid only drops when there really is a gap, so it never toggles in one step
   task automatic sender_gap();
      int gap;
      gap = tx_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Sender goes quiet until every outstanding request has been answered.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Register write only with the block idle.
   task automatic write_floor(input logic signed [PIXEL_BITS-1:0] value);
      drain_results();
      repeat (RSP_LATENCY) @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      floor_value = value;
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // single reset at the start of the run
   initial begin
      reset <= 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // Watchdog. Allows for the clearing sweep after reset and the slowest
   // legal pace on both sides, many times over.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("pixel_histogram_engine regression: fail");
         $finish;
      end
   end

   // Response side: random back-pressure in bursts, with steady stretches,
   // plus one long hold-off on request from the stimulus.
   initial begin
      int gap;
      int mode_left;
      bit rx_steady;
      rsp_chan.ready <= 1'b0;
      mode_left = 0;
      rx_steady = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_request) begin
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_off_request = 1'b0;
         end else begin
            if (mode_left == 0) begin
               rx_steady = ($urandom_range(0, 3) == 0);
               mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            gap = rx_steady ? 0 : pick_gap();
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
            if (gap > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   // Scoreboard: each response against the oldest outstanding request.
   always @(posedge clock) begin : check_responses
      phe_pkg::phe_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            $error("response with no request outstanding: bin_count %0d out_of_range %0d",
                   rsp_chan.bin_count, rsp_chan.out_of_range);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_chan.bin_count !== want.bin_count) begin
               $error("bin_count: expected %0d, got %0d", want.bin_count, rsp_chan.bin_count);
               mismatches++;
            end
            if (rsp_chan.out_of_range !== want.out_of_range) begin
               $error("out_of_range: expected %0d, got %0d",
                      want.out_of_range, rsp_chan.out_of_range);
               mismatches++;
            end
         end
      end
   end

   // Stimulus: directed table first, then random phases, one minimum pixel
   // setting per phase, extremes included.
   initial begin
      histo_req_type                r;
      phe_pkg::phe_result_type      no_result;
      logic signed [PIXEL_BITS-1:0] floor_next;
      int                           hot_base;

      req_chan.valid       <= 1'b0;
      req_chan.kind        <= phe_pkg::KIND_COUNT;
      req_chan.pixel_value <= '0;
      req_chan.bin_index   <= '0;
      csr_chan.valid       <= 1'b0;
      csr_chan.data        <= '0;

      hold_off_request = 1'b0;
      tx_steady        = 1'b0;
      no_result        = '0;
      floor_value      = '0;
      foreach (bin_tally[i]) bin_tally[i] = '0;

      do @(posedge clock); while (reset);

      // ready stays low through the clearing sweep; the handshake takes care
      foreach (directed_rows[i]) begin
         issue_request(directed_rows[i].req, directed_rows[i].known,
                       directed_rows[i].result);
         sender_gap();
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            case (phase)
               1:       floor_next = 16'sh8000;                   // most negative
               2:       floor_next = 16'sh7fff;                   // only one bin reachable
               3:       floor_next = PIXEL_BITS'($urandom);
               4:       floor_next = PIXEL_BITS'($urandom_range(0, 8191) - 4096);
               default: floor_next = '0;                          // back to reset value
            endcase
            write_floor(floor_next);
         end
         hot_base = $urandom_range(0, NUM_BINS - 16);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 50 == 0)
               tx_steady = ($urandom_range(0, 2) == 0);
            // response side holds off while requests keep coming: fills the
            // output buffer and must stall the request side
            if (phase == 1 && n == 51) begin
               hold_off_request = 1'b1;
               tx_steady        = 1'b1;
            end
            // sender pauses mid-phase until everything has come back
            if (phase == 2 && n == 100)
               drain_results();
            r = random_request(hot_base);
            issue_request(r, 1'b0, no_result);
            sender_gap();
         end
      end

      drain_results();
      repeat (RSP_LATENCY) @(posedge clock);
      if (mismatches == 0)
         $display("pixel_histogram_engine regression: pass");
      else
         $display("pixel_histogram_engine regression: fail");
      $finish;
   end

endmodule

@@ files.f @@
design/phe_pkg.sv
design/phe_channels.sv
design/phe_ram.sv
design/phe_update.sv
design/phe_out_fifo.sv
design/pixel_histogram_engine.sv
test/tb_pixel_histogram_engine.sv
